/* rtl/dssf_pkg.sv */
// Shared constants, types and functions of the decimal seven-segment formatter.
package dssf_pkg;

   localparam int DIGITS     = 8;
   localparam int BCD_DIGITS = 10;
   localparam int VALUE_W    = 32;
   localparam int COUNT_W    = 4;
   localparam int SEG_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int DIG_IDX_W  = $clog2(DIGITS);
   localparam int STAGES     = 4;
   localparam int STEPS      = VALUE_W / STAGES;

   localparam logic [CSR_IDX_W-1:0] CSR_MINUS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLANK    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVERFLOW = 2'd2;

   localparam logic [SEG_W-1:0] MINUS_RESET    = 8'h40;
   localparam logic [SEG_W-1:0] BLANK_RESET    = 8'h00;
   localparam logic [SEG_W-1:0] OVERFLOW_RESET = 8'h40;

   typedef struct packed {
      logic                      valid;
      logic                      neg;
      logic [COUNT_W-1:0]        cnt;
      logic [COUNT_W-1:0]        keep;
      logic [VALUE_W-1:0]        bin;
      logic [BCD_DIGITS*4-1:0]   bcd;
   } pipe_type;

   typedef struct packed {
      logic [SEG_W-1:0] minus;
      logic [SEG_W-1:0] blank;
      logic [SEG_W-1:0] overflow;
   } csr_type;

   function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] d);
      logic [SEG_W-1:0] s;
      case (d)
         4'd0:    s = 8'h3F;
         4'd1:    s = 8'h06;
         4'd2:    s = 8'h5B;
         4'd3:    s = 8'h4F;
         4'd4:    s = 8'h66;
         4'd5:    s = 8'h6D;
         4'd6:    s = 8'h7D;
         4'd7:    s = 8'h07;
         4'd8:    s = 8'h7F;
         4'd9:    s = 8'h6F;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   // One shift-and-add-3 step of the binary to BCD conversion.
   function automatic pipe_type bcd_step(input pipe_type p);
      pipe_type q;
      logic [BCD_DIGITS*4-1:0] adj;
      q = p;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i*4 +: 4] = (p.bcd[i*4 +: 4] >= 4'd5) ? p.bcd[i*4 +: 4] + 4'd3
                                                   : p.bcd[i*4 +: 4];
      end
      q.bcd = {adj[BCD_DIGITS*4-2:0], p.bin[VALUE_W-1]};
      q.bin = {p.bin[VALUE_W-2:0], 1'b0};
      return q;
   endfunction

endpackage

/* rtl/dssf_if.sv */
// Handshake channels for the formatter's requests and segment writes.
interface dssf_req_if;
   import dssf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value;
   logic [COUNT_W-1:0]         digit_count;
   logic [COUNT_W-1:0]         min_shown;
   modport source (output valid, value, digit_count, min_shown, input ready);
   modport sink   (input valid, value, digit_count, min_shown, output ready);
endinterface

interface dssf_rsp_if;
   import dssf_pkg::*;
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  position;
   logic [SEG_W-1:0]    segments;
   logic                last;
   modport source (output valid, position, segments, last, input ready);
   modport sink   (input valid, position, segments, last, output ready);
endinterface

/* rtl/decimal_seven_segment_formatter_unit.sv */
// Top level of the decimal seven-segment formatter.
//
// Usage: present a signed value, a digit count and a count of low digits
// always shown on req_ch; a request transfers when valid and ready are high.
// Each request yields nine segment writes on rsp_ch (position, pattern,
// last on the ninth): a minus sign if negative, blanks above the digits,
// then the digits from the top down with leading zeros blanked, or the
// overflow pattern on every digit if the magnitude does not fit.
// Patterns for minus, blank and overflow are written through the csr_ port;
// the user must write them only while the block is idle, which it does not enforce.
// A request passes the input register, then four binary to BCD stages of
// eight shifts each, then the serializer load before its first write appears.
// Throughput: one request per nine write transfers, set by the serializer
// that emits one write per cycle while the receiver is ready; the pipeline holds further requests.
// Reset clears every valid bit and restores the pattern registers.
// When the receiver stalls the current write holds, and the pipeline stops
// once its last stage holds an item; no request is lost or repeated.
module decimal_seven_segment_formatter_unit
   import dssf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   dssf_req_if.sink              req_ch,
   dssf_rsp_if.source            rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [SEG_W-1:0]      csr_write_data
);
   csr_type            csr_ff;
   pipe_type           in_ff, in_in;
   pipe_type           stage_q [STAGES+1];
   logic               move, free;
   logic [COUNT_W-1:0] cnt_sat;
   logic [VALUE_W-1:0] raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.minus    <= MINUS_RESET;
         csr_ff.blank    <= BLANK_RESET;
         csr_ff.overflow <= OVERFLOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MINUS:    csr_ff.minus    <= csr_write_data;
            CSR_BLANK:    csr_ff.blank    <= csr_write_data;
            CSR_OVERFLOW: csr_ff.overflow <= csr_write_data;
            default:      ;
         endcase
      end
   end

   // Advance the whole pipeline unless its last stage is held.
   assign move         = !stage_q[STAGES].valid || free;
   assign req_ch.ready = move;

   assign raw     = req_ch.value;
   assign cnt_sat = (req_ch.digit_count > COUNT_W'(DIGITS)) ? COUNT_W'(DIGITS)
                                                            : req_ch.digit_count;
   always_comb begin
      in_in.valid = req_ch.valid;
      in_in.neg   = raw[VALUE_W-1];
      in_in.cnt   = cnt_sat;
      in_in.keep  = (req_ch.min_shown > cnt_sat) ? cnt_sat : req_ch.min_shown;
      in_in.bin   = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
      in_in.bcd   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) in_ff.valid <= 1'b0;
      else if (move) in_ff <= in_in;
   end

   assign stage_q[0] = in_ff;

   for (genvar g = 0; g < STAGES; g++) begin : g_bcd
      dssf_bcd_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (move),
         .stage_in  (stage_q[g]),
         .stage_out (stage_q[g+1])
      );
   end

   dssf_serializer u_ser (
      .clock  (clock),
      .reset  (reset),
      .item   (stage_q[STAGES]),
      .csr    (csr_ff),
      .free   (free),
      .rsp_ch (rsp_ch)
   );
endmodule

/* rtl/dssf_bcd_stage.sv */
// One register stage of the binary to BCD pipeline: several shift steps.
module dssf_bcd_stage
   import dssf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     enable,
   input  pipe_type stage_in,
   output pipe_type stage_out
);
   pipe_type stage_ff;
   pipe_type stage_in_c;

   always_comb begin
      stage_in_c = stage_in;
      for (int s = 0; s < STEPS; s++) stage_in_c = bcd_step(stage_in_c);
   end

   always_ff @(posedge clock) begin
      if (reset) stage_ff.valid <= 1'b0;
      else if (enable) stage_ff <= stage_in_c;
   end

   assign stage_out = stage_ff;
endmodule

/* rtl/dssf_serializer.sv */
// Holds one converted item and emits its segment writes one per transfer.
module dssf_serializer
   import dssf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  pipe_type          item,
   input  csr_type           csr,
   output logic              free,
   dssf_rsp_if.source        rsp_ch
);
   logic                  busy_ff;
   logic [COUNT_W-1:0]    pos_ff, pos_in;
   logic [COUNT_W-1:0]    step_ff;
   logic                  seen_ff;
   logic                  neg_ff;
   logic [COUNT_W-1:0]    cnt_ff;
   logic [COUNT_W-1:0]    keep_ff;
   logic                  ovf_ff, ovf_in;
   logic [3:0]            dig_ff [DIGITS];
   logic                  load, xfer, final_step;
   logic [3:0]            cur_dig;
   logic                  digit_pos;

   assign xfer       = busy_ff && rsp_ch.ready;
   assign final_step = (step_ff == COUNT_W'(DIGITS));
   assign free       = !busy_ff || (xfer && final_step);
   assign load       = item.valid && free;

   always_comb begin
      ovf_in = 1'b0;
      for (int d = 0; d < BCD_DIGITS; d++) begin
         if (COUNT_W'(d) >= item.cnt && item.bcd[d*4 +: 4] != 4'd0) ovf_in = 1'b1;
      end
   end

   assign cur_dig   = dig_ff[pos_ff[DIG_IDX_W-1:0]];
   assign digit_pos = pos_ff < cnt_ff;

   // Walk up from the digit count to the top, then down through the digits.
   always_comb begin
      if (!digit_pos) pos_in = (pos_ff == COUNT_W'(DIGITS)) ? cnt_ff - 1'b1
                                                             : pos_ff + 1'b1;
      else pos_in = pos_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
         pos_ff  <= item.cnt;
         step_ff <= '0;
         seen_ff <= 1'b0;
         neg_ff  <= item.neg;
         cnt_ff  <= item.cnt;
         keep_ff <= item.keep;
         ovf_ff  <= ovf_in;
         for (int d = 0; d < DIGITS; d++) dig_ff[d] <= item.bcd[d*4 +: 4];
      end else if (xfer) begin
         if (final_step) busy_ff <= 1'b0;
         pos_ff  <= pos_in;
         step_ff <= step_ff + 1'b1;
         if (digit_pos && cur_dig != 4'd0) seen_ff <= 1'b1;
      end
   end

   always_comb begin
      if (!digit_pos) rsp_ch.segments = (neg_ff && pos_ff == cnt_ff) ? csr.minus : csr.blank;
      else if (ovf_ff) rsp_ch.segments = csr.overflow;
      else if (cur_dig != 4'd0 || seen_ff || pos_ff < keep_ff)
         rsp_ch.segments = seg_digit(cur_dig);
      else rsp_ch.segments = csr.blank;
   end

   assign rsp_ch.valid    = busy_ff;
   assign rsp_ch.position = pos_ff;
   assign rsp_ch.last     = final_step;
endmodule

/* bench/decimal_seven_segment_formatter_unit_tb.sv */
// Testbench for the decimal seven-segment formatter: random and directed requests, checked writes.
`timescale 1ns / 1ps
module decimal_seven_segment_formatter_unit_tb;
   import dssf_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        digit_count;
      logic [COUNT_W-1:0]        min_shown;
   } request_type;

   typedef struct packed {
      logic [COUNT_W-1:0] position;
      logic [SEG_W-1:0]   segments;
      logic               last;
   } write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MINUS;
   logic [SEG_W-1:0]     csr_write_data = '0;

   dssf_req_if req_ch();
   dssf_rsp_if rsp_ch();

   decimal_seven_segment_formatter_unit DUT (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   request_type pending_requests[$];
   write_type   expected_writes[$];
   logic [SEG_W-1:0] minus_seg = MINUS_RESET;
   logic [SEG_W-1:0] blank_seg = BLANK_RESET;
   logic [SEG_W-1:0] overflow_seg = OVERFLOW_RESET;
   int  errors = 0;
   int  cycles = 0;
   bit  hold_sender = 1'b0;
   bit  driving_enabled = 1'b0;
   int  req_gap = 0;
   int  rsp_gap = 0;

   function automatic logic [SEG_W-1:0] digit_seg(input int d);
      logic [SEG_W-1:0] lut [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                     8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};
      return lut[d];
   endfunction

   // Compute the nine writes for one request.
   function automatic void format_request(input request_type r);
      logic [63:0] mag;
      int cnt, keep, n, p, dig[DIGITS];
      bit neg, ovf, seen;
      write_type w;
      neg = r.value[VALUE_W-1];
      mag = neg ? 64'(-r.value[31:0]) & 64'hFFFF_FFFF : 64'(r.value[31:0]);
      cnt = (r.digit_count > DIGITS) ? DIGITS : r.digit_count;
      keep = (r.min_shown > cnt) ? cnt : r.min_shown;
      for (int i = 0; i < cnt; i++) begin
         dig[i] = int'(mag % 10);
         mag = mag / 10;
      end
      ovf = (mag != 0);
      seen = 1'b0;
      n = 0;
      p = cnt;
      if (neg) begin
         w = '{position: COUNT_W'(cnt), segments: minus_seg, last: 1'b0};
         expected_writes.push_back(w);
         n++;
         p = cnt + 1;
      end
      while (p <= DIGITS) begin
         w = '{position: COUNT_W'(p), segments: blank_seg, last: n == DIGITS};
         expected_writes.push_back(w);
         n++;
         p++;
      end
      for (int i = cnt - 1; i >= 0; i--) begin
         w.position = COUNT_W'(i);
         w.last = (n == DIGITS);
         if (ovf) w.segments = overflow_seg;
         else if (dig[i] != 0 || seen || i < keep) begin
            seen = 1'b1;
            w.segments = digit_seg(dig[i]);
         end else w.segments = blank_seg;
         expected_writes.push_back(w);
         n++;
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Driver: pull from the pending queue, predict on transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) format_request(
            '{value: req_ch.value, digit_count: req_ch.digit_count,
              min_shown: req_ch.min_shown});
         if (!req_ch.valid || req_ch.ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (driving_enabled && !hold_sender && pending_requests.size() > 0) begin
               request_type r;
               r = pending_requests.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.value <= r.value;
               req_ch.digit_count <= r.digit_count;
               req_ch.min_shown <= r.min_shown;
               req_gap <= pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each write transfer, toggle ready at random.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            write_type got, want;
            got = '{position: rsp_ch.position, segments: rsp_ch.segments,
                    last: rsp_ch.last};
            if (expected_writes.size() == 0) begin
               $display("%0t: write expected none actual %h", $time, got);
               errors++;
            end else begin
               want = expected_writes.pop_front();
               if (got.position !== want.position)
                  $display("%0t: position expected %0d actual %0d", $time,
                           want.position, got.position);
               if (got.segments !== want.segments)
                  $display("%0t: segments expected %h actual %h", $time,
                           want.segments, got.segments);
               if (got.last !== want.last)
                  $display("%0t: last expected %b actual %b", $time, want.last, got.last);
               if (got !== want) errors++;
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= pick_gap();
         end
      end
      if (cycles > 400000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic add_request(input logic [31:0] v, input int cnt, input int keep);
      request_type r;
      r.value = v;
      r.digit_count = COUNT_W'(cnt);
      r.min_shown = COUNT_W'(keep);
      pending_requests.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_ch.valid || expected_writes.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [SEG_W-1:0] d);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= d;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_MINUS:    minus_seg = d;
         CSR_BLANK:    blank_seg = d;
         CSR_OVERFLOW: overflow_seg = d;
         default: ;
      endcase
   endtask

   task automatic add_random(input int count);
      logic [31:0] v;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 99999999);
            2: v = -$urandom_range(0, 9999999);
            3: v = $urandom_range(0, 999);
            default: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(0, 15);
         endcase
         add_request(v, $urandom_range(0, 15), $urandom_range(0, 15));
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.digit_count = '0;
      req_ch.min_shown = '0;
      rsp_ch.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      driving_enabled = 1'b1;
      // Directed: extremes, blanking, overflow, out-of-range counts.
      add_request(32'h0, 8, 0);
      add_request(32'h0, 8, 8);
      add_request(32'h0, 0, 0);
      add_request(-32'sd5, 0, 0);
      add_request(32'h8000_0000, 8, 3);
      add_request(32'h7FFF_FFFF, 15, 15);
      add_request(32'd99999999, 8, 0);
      add_request(32'd100000000, 8, 0);
      add_request(-32'sd99999999, 8, 2);
      add_request(32'd1000, 3, 1);
      add_request(32'd1000, 4, 9);
      add_request(32'd7, 1, 0);
      add_request(-32'sd1, 1, 1);
      add_request(32'd1020304, 8, 5);
      add_request(32'd5, 15, 0);
      wait_drained();
      write_csr(CSR_MINUS, 8'hFF);
      write_csr(CSR_BLANK, 8'hAA);
      write_csr(CSR_OVERFLOW, 8'h00);
      write_csr(CSR_UNUSED, 8'h55);
      add_random(160);
      // Pause the sender until every write is back.
      while (pending_requests.size() > 80) @(posedge clock);
      hold_sender = 1'b1;
      while (req_ch.valid || expected_writes.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      hold_sender = 1'b0;
      wait_drained();
      write_csr(CSR_MINUS, 8'h00);
      write_csr(CSR_BLANK, 8'hFF);
      write_csr(CSR_OVERFLOW, 8'h55);
      add_random(160);
      wait_drained();
      write_csr(CSR_MINUS, MINUS_RESET);
      write_csr(CSR_BLANK, BLANK_RESET);
      write_csr(CSR_OVERFLOW, 8'hFF);
      add_random(145);
      wait_drained();
      if (errors == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule

/* decimal_seven_segment_formatter_unit.f */
rtl/dssf_pkg.sv
rtl/dssf_if.sv
rtl/dssf_bcd_stage.sv
rtl/dssf_serializer.sv
rtl/decimal_seven_segment_formatter_unit.sv
bench/decimal_seven_segment_formatter_unit_tb.sv
